// ===== rtl/cdfis_pkg.sv =====
`default_nettype none

package cdfis_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = 11;
	localparam int PROB_W      = 32;
	localparam int VAL_W       = 32;
	localparam int MAG_W       = 31;

	localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(1024);

	typedef enum logic {
		ACT_LOAD   = 1'b0,
		ACT_SAMPLE = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STEP,
		ST_CMP,
		ST_RESULT
	} state_t;

	typedef struct packed {
		action_t                   action;
		logic [IDX_W-1:0]          entry_index;
		logic [PROB_W-1:0]         cumulative_prob;
		logic signed [VAL_W-1:0]   sample_value;
		logic [PROB_W-1:0]         uniform_draw;
	} req_t;

	typedef struct packed {
		logic [IDX_W-1:0] found_index;
		logic [MAG_W-1:0] sample_magnitude;
	} rsp_t;

	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  waddr;
		logic [PROB_W-1:0] wcdf;
		logic [VAL_W-1:0]  wval;
		logic              re;
		logic [IDX_W-1:0]  raddr;
	} mem_req_t;

	typedef struct packed {
		logic [PROB_W-1:0] cdf;
		logic [VAL_W-1:0]  val;
	} mem_rd_t;

endpackage

`default_nettype wire

// ===== rtl/cdf_table_inverse_sampler_core.sv =====
`default_nettype none

// Channel  Direction  Handshake           Payload
// req      in         req_valid/req_stall  req_t (load or sample)
// rsp      out        rsp_valid/rsp_stall  rsp_t (index, magnitude)
// cfg      in         cfg_we               cfg_wdata (entry_count)
//
// A load is written into the table while idle and does not stall the request
// channel. A sample runs a bisection on the table read port, each step reading
// the middle entry and comparing it with the draw; an equal probe ends the
// search early, and a range of two entries or fewer returns its upper entry.
// One item is in work at a time; a finished result waits in the output
// register while the next item is taken. While rsp_stall holds a full output
// register, a finished search waits and req_stall stays high.
// Reset clears control only; table contents are undefined until loaded.
module cdf_table_inverse_sampler_core
	import cdfis_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_stall,
	input  req_t                  req,
	output logic                  rsp_valid,
	input  wire logic             rsp_stall,
	output rsp_t                  rsp,
	input  wire logic             cfg_we,
	input  wire logic [CNT_W-1:0] cfg_wdata
);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] eff_count;
	logic [IDX_W-1:0] last_index;
	mem_req_t         mreq;
	mem_rd_t          rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_RESET;
		end else if (cfg_we) begin
			count_q <= cfg_wdata;
		end
	end

	// clamp to the table size, at least one entry
	always_comb begin
		if (count_q > CNT_W'(TABLE_DEPTH)) begin
			eff_count = CNT_W'(TABLE_DEPTH);
		end else if (count_q == '0) begin
			eff_count = CNT_W'(1);
		end else begin
			eff_count = count_q;
		end
	end

	assign last_index = IDX_W'(eff_count - CNT_W'(1));

	cdfis_store u_store (
		.clk  (clk),
		.mreq (mreq),
		.rd   (rd)
	);

	cdfis_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.last_index (last_index),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.mreq       (mreq),
		.rd         (rd)
	);

`ifndef SYNTHESIS
	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && (req.action == ACT_SAMPLE) |=> req_stall)
		else $error("sample transaction did not start a search");

	a_load_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && (req.action == ACT_LOAD) |=> !req_stall)
		else $error("load transaction stalled the request channel");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.found_index <= last_index))
		else $error("result index beyond the searched range");

	a_rsp_from_search: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("result appeared without a search in work");
`endif

endmodule

`default_nettype wire

// ===== rtl/cdfis_store.sv =====
`default_nettype none

module cdfis_store
	import cdfis_pkg::*;
(
	input  wire logic     clk,
	input  mem_req_t      mreq,
	output mem_rd_t       rd
);

	logic [PROB_W-1:0] cdf_mem [TABLE_DEPTH];
	logic [VAL_W-1:0]  val_mem [TABLE_DEPTH];
	mem_rd_t           rd_q;

	always_ff @(posedge clk) begin
		if (mreq.we) begin
			cdf_mem[mreq.waddr] <= mreq.wcdf;
			val_mem[mreq.waddr] <= mreq.wval;
		end
	end

	always_ff @(posedge clk) begin
		if (mreq.re) begin
			rd_q.cdf <= cdf_mem[mreq.raddr];
			rd_q.val <= val_mem[mreq.raddr];
		end
	end

	assign rd = rd_q;

endmodule

`default_nettype wire

// ===== rtl/cdfis_ctrl.sv =====
`default_nettype none

module cdfis_ctrl
	import cdfis_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [IDX_W-1:0] last_index,
	input  wire logic             req_valid,
	output logic                  req_stall,
	input  req_t                  req,
	output logic                  rsp_valid,
	input  wire logic             rsp_stall,
	output rsp_t                  rsp,
	output mem_req_t              mreq,
	input  mem_rd_t               rd
);

	state_t            state_q;
	state_t            state_nxt;
	logic [IDX_W-1:0]  lo_q;
	logic [IDX_W-1:0]  hi_q;
	logic [IDX_W-1:0]  found_q;
	logic [PROB_W-1:0] draw_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;
	logic [IDX_W:0]    mid_sum;
	logic [IDX_W-1:0]  mid;
	logic [IDX_W-1:0]  span;
	logic              narrow;
	logic              take_sample;
	logic              rsp_free;
	logic [MAG_W-1:0]  mag;

	assign mid_sum     = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid         = mid_sum[IDX_W:1];
	assign span        = hi_q - lo_q;
	assign narrow      = (span == '0) || (span == IDX_W'(1));
	assign take_sample = req_valid && (req.action == ACT_SAMPLE);
	assign rsp_free    = !rsp_valid_q || !rsp_stall;

	always_comb begin
		if (rd.val == {1'b1, {(VAL_W-1){1'b0}}}) begin
			mag = '1;
		end else if (rd.val[VAL_W-1]) begin
			mag = MAG_W'(~rd.val + VAL_W'(1));
		end else begin
			mag = rd.val[MAG_W-1:0];
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (take_sample) state_nxt = ST_STEP;
			end
			ST_STEP: begin
				state_nxt = narrow ? ST_RESULT : ST_CMP;
			end
			ST_CMP: begin
				state_nxt = (rd.cdf == draw_q) ? ST_RESULT : ST_STEP;
			end
			ST_RESULT: begin
				if (rsp_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		req_stall  = (state_q != ST_IDLE);
		mreq.we    = (state_q == ST_IDLE) && req_valid && (req.action == ACT_LOAD);
		mreq.waddr = req.entry_index;
		mreq.wcdf  = req.cumulative_prob;
		mreq.wval  = req.sample_value;
		mreq.re    = (state_q == ST_STEP);
		mreq.raddr = narrow ? hi_q : mid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if ((state_q == ST_RESULT) && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (take_sample) begin
					lo_q   <= '0;
					hi_q   <= last_index;
					draw_q <= req.uniform_draw;
				end
			end
			ST_STEP: begin
				found_q <= narrow ? hi_q : mid;
			end
			ST_CMP: begin
				// narrow toward the probed entry
				if (draw_q < rd.cdf) begin
					hi_q <= found_q;
				end else if (draw_q > rd.cdf) begin
					lo_q <= found_q;
				end
			end
			ST_RESULT: begin
				if (rsp_free) begin
					rsp_q.found_index      <= found_q;
					rsp_q.sample_magnitude <= mag;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cdfis_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 400;
	localparam int LATENCY_PAD    = 40;
	localparam int RANDOM_ITEMS   = 480;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             req_valid = 1'b0;
	logic             req_stall;
	req_t             req       = '0;
	logic             rsp_valid;
	logic             rsp_stall = 1'b0;
	rsp_t             rsp;
	logic             cfg_we    = 1'b0;
	logic [CNT_W-1:0] cfg_wdata = '0;

	cdf_table_inverse_sampler_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow copy of the table and the count register
	logic [PROB_W-1:0] cdf_tab [TABLE_DEPTH];
	logic [VAL_W-1:0]  val_tab [TABLE_DEPTH];
	bit                loaded  [TABLE_DEPTH];
	logic [CNT_W-1:0]  count_reg = COUNT_RESET;

	rsp_t expected_rsp_q [$];
	int   mismatch_count = 0;
	int   items_sent     = 0;
	int   quiet_cycles   = 0;

	int hold_token = 0;
	int hold_seen  = 0;
	int hold_left  = 0;
	int stall_mode = 0;
	int mode_left  = 0;

	function automatic int unsigned active_count();
		int unsigned c;
		c = count_reg;
		if (c > TABLE_DEPTH) c = TABLE_DEPTH;
		if (c < 1) c = 1;
		return c;
	endfunction

	// gap returns the first touched entry that was never loaded, or -1
	function automatic int unsigned search_index(input logic [PROB_W-1:0] draw, output int gap);
		int unsigned lo, hi, mid;
		lo  = 0;
		hi  = active_count() - 1;
		gap = -1;
		while (!(lo == hi || lo + 1 == hi)) begin
			mid = (lo + hi) >> 1;
			if (!loaded[mid]) begin
				gap = mid;
				return mid;
			end
			if (draw < cdf_tab[mid]) hi = mid;
			else if (draw > cdf_tab[mid]) lo = mid;
			else return mid;
		end
		if (!loaded[hi]) gap = hi;
		return hi;
	endfunction

	function automatic logic [MAG_W-1:0] abs_sat(input logic [VAL_W-1:0] raw);
		logic [VAL_W-1:0] neg;
		neg = ~raw + 32'd1;
		if (raw == 32'h8000_0000) return '1;
		if (raw[VAL_W-1]) return neg[MAG_W-1:0];
		return raw[MAG_W-1:0];
	endfunction

	function automatic logic [PROB_W-1:0] ramp_cdf(input int unsigned idx);
		return PROB_W'(((64'(idx) << 32) + 64'($urandom)) / 64'(active_count()));
	endfunction

	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic req_t make_load(input int unsigned idx, input logic [PROB_W-1:0] cdf,
			input logic [VAL_W-1:0] value);
		req_t item;
		item.action          = ACT_LOAD;
		item.entry_index     = IDX_W'(idx);
		item.cumulative_prob = cdf;
		item.sample_value    = value;
		item.uniform_draw    = $urandom;
		return item;
	endfunction

	function automatic req_t make_sample(input logic [PROB_W-1:0] draw);
		req_t item;
		item.action          = ACT_SAMPLE;
		item.entry_index     = IDX_W'($urandom);
		item.cumulative_prob = $urandom;
		item.sample_value    = $urandom;
		item.uniform_draw    = draw;
		return item;
	endfunction

	task automatic push_request(input req_t item);
		rsp_t        predicted;
		int          gap;
		int unsigned pos;
		@(negedge clk);
		req_valid <= 1'b1;
		req       <= item;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		items_sent++;
		if (item.action == ACT_LOAD) begin
			cdf_tab[item.entry_index] = item.cumulative_prob;
			val_tab[item.entry_index] = item.sample_value;
			loaded[item.entry_index]  = 1'b1;
		end else begin
			pos = search_index(item.uniform_draw, gap);
			predicted.found_index      = IDX_W'(pos);
			predicted.sample_magnitude = abs_sat(val_tab[pos]);
			expected_rsp_q.push_back(predicted);
		end
	endtask

	// load every entry the search would touch, then draw
	task automatic draw_sample(input logic [PROB_W-1:0] draw);
		int          gap;
		int unsigned pos;
		pos = search_index(draw, gap);
		while (gap >= 0) begin
			push_request(make_load(gap, ramp_cdf(gap), pick_value()));
			pos = search_index(draw, gap);
		end
		push_request(make_sample(draw));
	endtask

	task automatic idle_req(input int n);
		if (n > 0) begin
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic wait_drain();
		@(negedge clk);
		req_valid <= 1'b0;
		while (expected_rsp_q.size() != 0) @(posedge clk);
	endtask

	task automatic set_count(input logic [CNT_W-1:0] value);
		wait_drain();
		repeat (LATENCY_PAD) @(posedge clk);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		count_reg = value;
	endtask

	task automatic test_reset_count();
		draw_sample(32'hFFFF_FFFF);
	endtask

	task automatic test_small_counts();
		set_count(11'd0);
		push_request(make_load(0, 32'h0000_0000, 32'h8000_0000));
		draw_sample($urandom);
		set_count(11'd1);
		draw_sample($urandom);
		set_count(11'd2);
		draw_sample($urandom);
	endtask

	task automatic test_equal_draw();
		set_count(11'd4);
		push_request(make_load(1, 32'h4000_0000, 32'h7FFF_FFFF));
		push_request(make_load(2, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		push_request(make_load(3, 32'h8000_0000, 32'h0000_0000));
		draw_sample(32'h4000_0000);
		draw_sample(32'h0000_0000);
		draw_sample(32'hFFFF_FFFF);
		draw_sample(32'h5000_0000);
	endtask

	task automatic test_wide_count();
		set_count(11'd2047);
		draw_sample($urandom);
		set_count(11'd1025);
		draw_sample($urandom);
	endtask

	task automatic test_backpressure();
		set_count(11'd16);
		@(posedge clk);
		hold_token++;
		repeat (12) draw_sample($urandom);
		wait_drain();
	endtask

	task automatic test_random_traffic();
		int          start_items;
		int          phase_len;
		int          phase_done;
		int          burst_left;
		int unsigned idx;
		int unsigned sel;
		logic [PROB_W-1:0] draw;
		start_items = items_sent;
		burst_left  = 0;
		while (items_sent - start_items < RANDOM_ITEMS) begin
			sel = $urandom_range(0, 99);
			if (sel < 10) begin
				case ($urandom_range(0, 2))
					0: set_count(11'd1024);
					1: set_count(11'd1025);
					default: set_count(11'd2047);
				endcase
			end else if (sel < 18) begin
				set_count(CNT_W'($urandom_range(0, 3)));
			end else begin
				set_count(CNT_W'($urandom_range(2, 48)));
			end
			phase_len  = $urandom_range(20, 50);
			phase_done = 0;
			while (phase_done < phase_len && items_sent - start_items < RANDOM_ITEMS) begin
				if (burst_left == 0) begin
					if ($urandom_range(0, 3) != 0) idle_req($urandom_range(1, 8));
					burst_left = $urandom_range(1, 16);
				end
				sel = $urandom_range(0, 99);
				if (sel < 25) begin
					if ($urandom_range(0, 4) != 0) begin
						idx = $urandom_range(0, active_count() - 1);
						push_request(make_load(idx, ramp_cdf(idx), pick_value()));
					end else begin
						push_request(make_load($urandom_range(0, TABLE_DEPTH - 1), $urandom,
							pick_value()));
					end
				end else begin
					sel = $urandom_range(0, 9);
					idx = $urandom_range(0, active_count() - 1);
					if (sel < 4 && loaded[idx]) draw = cdf_tab[idx];
					else if (sel == 4) draw = 32'h0000_0000;
					else if (sel == 5) draw = 32'hFFFF_FFFF;
					else draw = $urandom;
					draw_sample(draw);
				end
				if ($urandom_range(0, 99) < 3) wait_drain();
				burst_left--;
				phase_done++;
			end
		end
	endtask

	// receiver stall pattern, with a long hold-off on request
	always @(negedge clk) begin
		if (hold_token != hold_seen) begin
			hold_seen = hold_token;
			hold_left = HOLD_CYCLES;
		end
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			mode_left  = $urandom_range(5, 60);
		end else begin
			mode_left--;
		end
		if (hold_left != 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			case (stall_mode)
				0: rsp_stall <= 1'b0;
				1: rsp_stall <= ($urandom_range(0, 3) == 0);
				2: rsp_stall <= ($urandom_range(0, 3) != 0);
				default: rsp_stall <= 1'($urandom_range(0, 1));
			endcase
		end
	end

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsp_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: found_index %0d sample_magnitude %h",
						rsp.found_index, rsp.sample_magnitude);
			end else begin
				want = expected_rsp_q.pop_front();
				if (rsp.found_index !== want.found_index ||
						rsp.sample_magnitude !== want.sample_magnitude) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("result mismatch: found_index exp %0d got %0d, %s %h got %h",
							want.found_index, rsp.found_index, "sample_magnitude exp",
							want.sample_magnitude, rsp.sample_magnitude);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_count();
		test_small_counts();
		test_equal_draw();
		test_wide_count();
		test_backpressure();
		test_random_traffic();
		wait_drain();
		repeat (LATENCY_PAD) @(posedge clk);
		if (mismatch_count == 0 && expected_rsp_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

`default_nettype wire
